[src/mneq_pkg.sv]
// shared types, constants and helpers of the midi note event queue
package mneq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [7:0] STATUS_MASK = 8'hF0;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [1:0] MIN_BYTES   = 2'd3;

    localparam int ENTRY_W = 47;

    typedef struct packed {
        logic [6:0]  pitch;
        logic [6:0]  vel;
        logic        on;
        logic [31:0] tick;
    } t_entry;

    typedef struct packed {
        logic wr;
        logic poll;
        logic rd;
        logic eval;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic msg_ok;
        logic empty;
        logic idx_last;
    } t_stat;

    // floor(v * 65535 / 127) = 516 * v + floor(3 * v / 127)
    function automatic logic [15:0] vel_scale(logic [6:0] v);
        logic [8:0]  t3;
        logic [1:0]  corr;
        logic [15:0] base;
        t3 = {2'b00, v} + {1'b0, v, 1'b0};
        if (t3 >= 9'd381) begin
            corr = 2'd3;
        end else if (t3 >= 9'd254) begin
            corr = 2'd2;
        end else if (t3 >= 9'd127) begin
            corr = 2'd1;
        end else begin
            corr = 2'd0;
        end
        base = {9'd0, v} * 16'd516;
        return base + {14'd0, corr};
    endfunction

endpackage

[src/midi_note_event_queue.sv]
// top level of the midi note event queue
//
// channel   direction  handshake             fields
// command   in         start high, busy low  i_mode i_byte_count i_status_byte i_data_one
//                                            i_data_two i_now_tick i_caller_time
// result    out        o_strobe, one cycle   o_has_note o_note_pitch o_note_velocity
//                                            o_event_time o_drop_total o_last
//
// a message word is taken while idle and busy stays low
// a poll does one ram read and one evaluate per queued entry, then a closing step
// each result word is registered and shows in the cycle after the next note-on entry is evaluated,
// the final one after the closing step; the receiver cannot stall
// synchronous active low reset empties the queue and clears the drop count
module midi_note_event_queue
    import mneq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [1:0]  i_byte_count,
    input  logic [7:0]  i_status_byte,
    input  logic [7:0]  i_data_one,
    input  logic [7:0]  i_data_two,
    input  logic [31:0] i_now_tick,
    input  logic signed [47:0] i_caller_time,
    output logic        o_strobe,
    output logic        o_has_note,
    output logic [6:0]  o_note_pitch,
    output logic [15:0] o_note_velocity,
    output logic signed [47:0] o_event_time,
    output logic [15:0] o_drop_total,
    output logic        o_last
);

    t_cmd  cmd;
    t_stat stat;

    mneq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    mneq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_byte_count    (i_byte_count),
        .i_status_byte   (i_status_byte),
        .i_data_one      (i_data_one),
        .i_data_two      (i_data_two),
        .i_now_tick      (i_now_tick),
        .i_caller_time   (i_caller_time),
        .o_strobe        (o_strobe),
        .o_has_note      (o_has_note),
        .o_note_pitch    (o_note_pitch),
        .o_note_velocity (o_note_velocity),
        .o_event_time    (o_event_time),
        .o_drop_total    (o_drop_total),
        .o_last          (o_last)
    );

endmodule

[src/mneq_ram.sv]
// generic single write port ram with registered read
module mneq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/mneq_ctrl.sv]
// controller state machine of the midi note event queue
module mneq_ctrl
    import mneq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_mode,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode) begin
                        o_cmd.poll = 1'b1;
                        n_state    = i_stat.empty ? S_FIN : S_READ;
                    end else begin
                        o_cmd.wr = i_stat.msg_ok;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.idx_last ? S_FIN : S_READ;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[src/mneq_dp.sv]
// datapath of the midi note event queue: entry ram, pointers, drop count, result word
module mneq_dp
    import mneq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_byte_count,
    input  logic [7:0]  i_status_byte,
    input  logic [7:0]  i_data_one,
    input  logic [7:0]  i_data_two,
    input  logic [31:0] i_now_tick,
    input  logic signed [47:0] i_caller_time,
    output logic        o_strobe,
    output logic        o_has_note,
    output logic [6:0]  o_note_pitch,
    output logic [15:0] o_note_velocity,
    output logic signed [47:0] o_event_time,
    output logic [15:0] o_drop_total,
    output logic        o_last
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    function automatic logic [AW-1:0] f_wrap(logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= SW'(QUEUE_DEPTH)) ? s - SW'(QUEUE_DEPTH) : s;
        return t[AW-1:0];
    endfunction

    logic [AW-1:0] r_head,   n_head;
    logic [CW-1:0] r_count,  n_count;
    logic [15:0]   r_drops,  n_drops;
    logic [CW-1:0] r_idx,    n_idx;
    logic          r_pend_vld, n_pend_vld;
    logic          r_strobe, n_strobe;
    logic [31:0]   r_now;
    logic [47:0]   r_ctime;
    logic [6:0]    r_pend_pitch;
    logic [6:0]    r_pend_vel;
    logic [31:0]   r_pend_age;
    logic          r_has, r_last;
    logic [6:0]    r_pitch;
    logic [15:0]   r_vel;
    logic [47:0]   r_time;
    logic [15:0]   r_out_drops;

    logic          full;
    logic [AW-1:0] waddr, raddr;
    t_entry        wentry, rentry;
    logic [ENTRY_W-1:0] rdata;
    logic [7:0]    stat_type;
    logic          load_out;

    assign stat_type = i_status_byte & STATUS_MASK;
    assign full      = (r_count == CW'(QUEUE_DEPTH));

    assign wentry.pitch = i_data_one[6:0];
    assign wentry.vel   = i_data_two[6:0];
    assign wentry.on    = (stat_type == ST_NOTE_ON) && (i_data_two[6:0] != 7'd0);
    assign wentry.tick  = i_now_tick;

    assign waddr = full ? r_head : f_wrap(SW'(r_head) + SW'(r_count));
    assign raddr = f_wrap(SW'(r_head) + SW'(r_idx));

    mneq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (waddr),
        .i_wdata (wentry),
        .i_re    (i_cmd.rd),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rentry = t_entry'(rdata);

    assign o_stat.msg_ok   = (i_byte_count >= MIN_BYTES) &&
                             ((stat_type == ST_NOTE_ON) || (stat_type == ST_NOTE_OFF));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.idx_last = (CW'(r_idx + CW'(1)) == r_count);

    assign load_out = (i_cmd.eval && rentry.on && r_pend_vld) || i_cmd.finish;

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_drops    = r_drops;
        n_idx      = r_idx;
        n_pend_vld = r_pend_vld;
        n_strobe   = load_out;
        if (i_cmd.wr) begin
            if (full) begin
                n_head = f_wrap(SW'(r_head) + SW'(1));
                if (r_drops != 16'hFFFF) begin
                    n_drops = r_drops + 16'd1;
                end
            end else begin
                n_count = r_count + CW'(1);
            end
        end
        if (i_cmd.poll) begin
            n_idx      = '0;
            n_pend_vld = 1'b0;
        end
        if (i_cmd.eval) begin
            n_idx = CW'(r_idx + CW'(1));
            if (rentry.on) begin
                n_pend_vld = 1'b1;
            end
        end
        if (i_cmd.finish) begin
            n_head     = '0;
            n_count    = '0;
            n_drops    = '0;
            n_pend_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_drops    <= '0;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_count    <= n_count;
            r_drops    <= n_drops;
            r_idx      <= n_idx;
            r_pend_vld <= n_pend_vld;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.poll) begin
            r_now   <= i_now_tick;
            r_ctime <= i_caller_time;
        end
        if (i_cmd.eval && rentry.on) begin
            r_pend_pitch <= rentry.pitch;
            r_pend_vel   <= rentry.vel;
            r_pend_age   <= r_now - rentry.tick;
        end
        if (load_out) begin
            r_out_drops <= r_drops;
            r_last      <= i_cmd.finish;
            if (r_pend_vld) begin
                r_has   <= 1'b1;
                r_pitch <= r_pend_pitch;
                r_vel   <= vel_scale(r_pend_vel);
                r_time  <= r_ctime - {16'd0, r_pend_age};
            end else begin
                r_has   <= 1'b0;
                r_pitch <= '0;
                r_vel   <= '0;
                r_time  <= '0;
            end
        end
    end

    assign o_strobe        = r_strobe;
    assign o_has_note      = r_has;
    assign o_note_pitch    = r_pitch;
    assign o_note_velocity = r_vel;
    assign o_event_time    = r_time;
    assign o_drop_total    = r_out_drops;
    assign o_last          = r_last;

endmodule

[src/mneq_chk.sv]
// port level checker of the midi note event queue and its bind
module mneq_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_mode,
    input logic        o_strobe,
    input logic        o_has_note,
    input logic [6:0]  o_note_pitch,
    input logic [15:0] o_note_velocity,
    input logic [47:0] o_event_time,
    input logic        o_last
);

    a_msg_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_mode) |=> !o_strobe)
        else $error("result word right after a message");

    a_poll_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode) |=> busy)
        else $error("busy low right after a poll");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_has_note) |->
        (o_last && (o_note_pitch == 7'd0) && (o_note_velocity == 16'd0) &&
         (o_event_time == 48'd0)))
        else $error("empty poll word malformed");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("word right after last");

endmodule

bind midi_note_event_queue mneq_chk u_mneq_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_mode          (i_mode),
    .o_strobe        (o_strobe),
    .o_has_note      (o_has_note),
    .o_note_pitch    (o_note_pitch),
    .o_note_velocity (o_note_velocity),
    .o_event_time    (o_event_time),
    .o_last          (o_last)
);

[tb/testbench.sv]
// self-checking testbench for the midi note event queue, scoreboard and stimulus in one module
module testbench
    import mneq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_MSG  = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    localparam int RANDOM_WORDS   = 70;
    localparam int OVERFLOW_WORDS = 20;
    localparam int SETTLE_CYCLES  = 2 * QUEUE_DEPTH_DEF + 8;
    localparam int CYCLE_LIMIT    = 60000;

    localparam logic [47:0] TIME_MIN = 48'h8000_0000_0000;
    localparam logic [47:0] TIME_MAX = 48'h7FFF_FFFF_FFFF;

    typedef struct packed {
        logic        mode;
        logic [1:0]  byte_count;
        logic [7:0]  status_byte;
        logic [7:0]  data_one;
        logic [7:0]  data_two;
        logic [31:0] now_tick;
        logic [47:0] caller_time;
    } t_midi_word;

    typedef struct packed {
        logic        has_note;
        logic [6:0]  note_pitch;
        logic [15:0] note_velocity;
        logic [47:0] event_time;
        logic [15:0] drop_total;
        logic        last;
    } t_note_event;

    class note_queue_scoreboard;
        t_entry      queued_notes[$];
        logic [15:0] dropped_notes;
        t_note_event awaited_events[$];
        int          error_total;

        function new();
            dropped_notes = '0;
            error_total   = 0;
        endfunction

        function void note_word(t_midi_word w);
            t_entry      e;
            t_note_event ev;
            logic [7:0]  kind;
            logic [31:0] age;
            int          emitted;
            if (w.mode == MODE_MSG) begin
                kind = w.status_byte & STATUS_MASK;
                if (w.byte_count < MIN_BYTES) return;
                if (kind != ST_NOTE_ON && kind != ST_NOTE_OFF) return;
                e.pitch = w.data_one[6:0];
                e.vel   = w.data_two[6:0];
                e.on    = (kind == ST_NOTE_ON) && (e.vel != 7'd0);
                e.tick  = w.now_tick;
                if (queued_notes.size() >= QUEUE_DEPTH_DEF) begin
                    void'(queued_notes.pop_front());
                    if (dropped_notes != 16'hFFFF) dropped_notes++;
                end
                queued_notes.insert(queued_notes.size(), e);
            end else begin
                emitted = 0;
                foreach (queued_notes[i]) begin
                    if (queued_notes[i].on) begin
                        age              = w.now_tick - queued_notes[i].tick;
                        ev.has_note      = 1'b1;
                        ev.note_pitch    = queued_notes[i].pitch;
                        ev.note_velocity =
                            16'((32'(queued_notes[i].vel) * 32'd65535) / 32'd127);
                        ev.event_time    = w.caller_time - {16'd0, age};
                        ev.drop_total    = dropped_notes;
                        ev.last          = 1'b0;
                        awaited_events.insert(awaited_events.size(), ev);
                        emitted++;
                    end
                end
                if (emitted == 0) begin
                    ev            = '0;
                    ev.drop_total = dropped_notes;
                    ev.last       = 1'b1;
                    awaited_events.insert(awaited_events.size(), ev);
                end else begin
                    awaited_events[awaited_events.size() - 1].last = 1'b1;
                end
                queued_notes.delete();
                dropped_notes = '0;
            end
        endfunction

        function void compare_field(string field, logic [47:0] want, logic [47:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", field, want, got);
                error_total++;
            end
        endfunction

        function void check_result(t_note_event got);
            t_note_event want;
            if (awaited_events.size() == 0) begin
                $error("result word with nothing expected: pitch %0h time %0h",
                       got.note_pitch, got.event_time);
                error_total++;
                return;
            end
            want = awaited_events.pop_front();
            compare_field("has_note", want.has_note, got.has_note);
            compare_field("note_pitch", want.note_pitch, got.note_pitch);
            compare_field("note_velocity", want.note_velocity, got.note_velocity);
            compare_field("event_time", want.event_time, got.event_time);
            compare_field("drop_total", want.drop_total, got.drop_total);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    logic        i_mode        = MODE_MSG;
    logic [1:0]  i_byte_count  = '0;
    logic [7:0]  i_status_byte = '0;
    logic [7:0]  i_data_one    = '0;
    logic [7:0]  i_data_two    = '0;
    logic [31:0] i_now_tick    = '0;
    logic [47:0] i_caller_time = '0;
    logic        o_strobe;
    logic        o_has_note;
    logic [6:0]  o_note_pitch;
    logic [15:0] o_note_velocity;
    logic [47:0] o_event_time;
    logic [15:0] o_drop_total;
    logic        o_last;

    note_queue_scoreboard sb = new();
    int unsigned calm_left = 0;
    int unsigned cycle_count = 0;

    midi_note_event_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_byte_count   (i_byte_count),
        .i_status_byte  (i_status_byte),
        .i_data_one     (i_data_one),
        .i_data_two     (i_data_two),
        .i_now_tick     (i_now_tick),
        .i_caller_time  (i_caller_time),
        .o_strobe       (o_strobe),
        .o_has_note     (o_has_note),
        .o_note_pitch   (o_note_pitch),
        .o_note_velocity(o_note_velocity),
        .o_event_time   (o_event_time),
        .o_drop_total   (o_drop_total),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_result({o_has_note, o_note_pitch, o_note_velocity,
                             o_event_time, o_drop_total, o_last});
        end
    end

    // idle gaps, with occasional stretches of back-to-back words
    function automatic int unsigned pick_gap();
        if (calm_left == 0 && $urandom_range(0, 9) == 0) calm_left = $urandom_range(4, 20);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [47:0] pick_caller_time();
        case ($urandom_range(0, 7))
            0:       return TIME_MIN;
            1:       return TIME_MAX;
            2:       return 48'($urandom_range(0, 1000));
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic t_midi_word msg_word(logic [7:0] status, logic [1:0] bytes,
                                           logic [7:0] d1, logic [7:0] d2,
                                           logic [31:0] tick);
        t_midi_word w;
        w.mode        = MODE_MSG;
        w.byte_count  = bytes;
        w.status_byte = status;
        w.data_one    = d1;
        w.data_two    = d2;
        w.now_tick    = tick;
        w.caller_time = 48'({$urandom, $urandom});
        return w;
    endfunction

    function automatic t_midi_word poll_word(logic [31:0] tick, logic [47:0] ctime);
        t_midi_word w;
        w.mode        = MODE_POLL;
        w.byte_count  = 2'($urandom);
        w.status_byte = 8'($urandom);
        w.data_one    = 8'($urandom);
        w.data_two    = 8'($urandom);
        w.now_tick    = tick;
        w.caller_time = ctime;
        return w;
    endfunction

    function automatic t_midi_word note_word(logic [31:0] tick);
        logic [7:0] status;
        logic [7:0] vel;
        status = ($urandom_range(0, 1) ? ST_NOTE_ON : ST_NOTE_OFF) | {4'h0, 4'($urandom)};
        vel    = ($urandom_range(0, 9) == 0) ? {1'($urandom), 7'd0} : 8'($urandom);
        return msg_word(status, MIN_BYTES, 8'($urandom), vel, tick);
    endfunction

    task automatic send_word(input t_midi_word w, input int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_mode        <= w.mode;
        i_byte_count  <= w.byte_count;
        i_status_byte <= w.status_byte;
        i_data_one    <= w.data_one;
        i_data_two    <= w.data_two;
        i_now_tick    <= w.now_tick;
        i_caller_time <= w.caller_time;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_word(w);
    endtask

    initial begin
        logic [31:0] tick;
        int unsigned roll;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words
        send_word(poll_word(32'd0, 48'd0), pick_gap());
        send_word(msg_word(8'h9F, MIN_BYTES, 8'hFF, 8'hFF, 32'hFFFF_FFF0), pick_gap());
        send_word(msg_word(8'h90, MIN_BYTES, 8'h80, 8'h80, 32'hFFFF_FFF4), pick_gap());
        send_word(msg_word(8'h8A, MIN_BYTES, 8'h3C, 8'h40, 32'hFFFF_FFF8), pick_gap());
        send_word(msg_word(8'h93, 2'd2, 8'h3C, 8'h40, 32'hFFFF_FFF9), pick_gap());
        send_word(msg_word(8'h95, 2'd0, 8'h3D, 8'h41, 32'hFFFF_FFFA), pick_gap());
        send_word(msg_word(8'hA0, MIN_BYTES, 8'h3E, 8'h42, 32'hFFFF_FFFB), pick_gap());
        send_word(msg_word(8'hFF, MIN_BYTES, 8'h3F, 8'h43, 32'hFFFF_FFFC), pick_gap());
        send_word(msg_word(8'h00, MIN_BYTES, 8'h40, 8'h44, 32'hFFFF_FFFD), pick_gap());
        send_word(msg_word(8'h7F, MIN_BYTES, 8'h41, 8'h45, 32'hFFFF_FFFE), pick_gap());
        send_word(msg_word(8'h91, MIN_BYTES, 8'h00, 8'h01, 32'h0000_0010), pick_gap());
        send_word(msg_word(8'h9C, 2'd1, 8'h40, 8'h7E, 32'h0000_0018), pick_gap());
        send_word(msg_word(8'h9C, MIN_BYTES, 8'h40, 8'h7E, 32'h0000_0020), pick_gap());
        send_word(poll_word(32'h0000_0030, TIME_MIN), pick_gap());
        send_word(msg_word(8'h90, MIN_BYTES, 8'h41, 8'h7F, 32'h0000_0100), pick_gap());
        send_word(poll_word(32'hFFFF_0100, TIME_MAX), pick_gap());
        send_word(msg_word(8'h80, MIN_BYTES, 8'h22, 8'h33, 32'h0000_0200), pick_gap());
        send_word(poll_word(32'h0000_0300, 48'h0000_1234_5678), pick_gap());
        send_word(poll_word(32'h0000_0400, 48'hFFFF_FFFF_FFFF), pick_gap());

        // overflow the queue so the oldest entries get dropped
        tick = $urandom;
        for (int i = 0; i < OVERFLOW_WORDS; i++) begin
            tick += $urandom_range(0, 50);
            send_word(note_word(tick), 0);
        end
        send_word(poll_word(tick + 32'd7, pick_caller_time()), 0);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) tick = $urandom;
            else tick += $urandom_range(0, 3000);
            if (roll < 10) begin
                send_word(poll_word(tick, pick_caller_time()), pick_gap());
            end else if (roll < 80) begin
                send_word(note_word(tick), pick_gap());
            end else begin
                send_word(msg_word(8'($urandom), 2'($urandom), 8'($urandom), 8'($urandom),
                                   tick), pick_gap());
            end
        end
        send_word(poll_word(tick + 32'd1, pick_caller_time()), pick_gap());
        start <= 1'b0;

        while (sb.awaited_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.error_total == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
